[rtl/core/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants for the monotone chain hull block
// point layout and sort order
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned MaxPointsDefault = 64;
  localparam int unsigned FracBitsDefault  = 23;
  localparam int unsigned LatW = 31;
  localparam int unsigned LonW = 32;

  typedef struct packed {
    logic signed [LonW-1:0] lon;
    logic signed [LatW-1:0] lat;
  } pt_t;

  // true when a sorts strictly before b
  function automatic logic pt_before(pt_t a, pt_t b);
    logic r;
    if (a.lon != b.lon) begin
      r = (a.lon < b.lon);
    end else begin
      r = (a.lat < b.lat);
    end
    return r;
  endfunction

endpackage

[rtl/core/chm_sort_cell.sv]
// ----------------------------------------------------------------------------
// chm_sort_cell: one cell of the insertion sorting chain
// keeps the smaller point, passes the larger one to its right neighbor
// ----------------------------------------------------------------------------
module chm_sort_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          in_valid,
  input  chm_pkg::pt_t  in_pt,
  output logic          out_valid,
  output chm_pkg::pt_t  out_pt,
  output chm_pkg::pt_t  held
);
  import chm_pkg::*;

  logic full;
  logic keep_new;

  assign keep_new = !full || pt_before(in_pt, held);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      full      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid && full;
      if (in_valid) begin
        full <= 1'b1;
        if (keep_new) begin
          held   <= in_pt;
          out_pt <= held;
        end else begin
          out_pt <= in_pt;
        end
      end
    end
  end

endmodule

[rtl/core/chm_scan.sv]
// ----------------------------------------------------------------------------
// chm_scan: one hull scan over the sorted points with a point stack
// cross product made from two registered 33x33 products
// ----------------------------------------------------------------------------
module chm_scan #(
  parameter int unsigned MAX_POINTS = chm_pkg::MaxPointsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         upper,
  input  logic [$clog2(MAX_POINTS+1)-1:0] count,
  output logic [$clog2(MAX_POINTS)-1:0]   pt_idx,
  input  chm_pkg::pt_t                 pt_in,
  output logic                         done,
  output logic [$clog2(MAX_POINTS+1)-1:0] depth,
  input  logic [$clog2(MAX_POINTS)-1:0]   rd_idx,
  output chm_pkg::pt_t                 rd_pt
);
  import chm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS+1);
  localparam int unsigned IW = $clog2(MAX_POINTS);

  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_TEST, S_MUL, S_CMP, S_REFILL, S_PUSH} st_t;

  st_t st;
  pt_t stk [MAX_POINTS];
  logic [CW-1:0] i;
  pt_t p;
  // top two stack entries kept in registers for the cross product
  pt_t top_a, top_o;
  logic [IW-1:0] refill_idx;
  logic signed [32:0] dx1, dy2, dy1, dx2;
  logic signed [65:0] p1, p2;
  logic pop;

  assign pt_idx = i[IW-1:0];
  assign rd_pt  = stk[rd_idx];
  // after a pop the new second entry sits two below the new depth
  assign refill_idx = IW'(depth - CW'(2));

  always_comb begin
    pop = upper ? (p1 >= p2) : (p1 <= p2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      done  <= 1'b0;
      depth <= '0;
      i     <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (start) begin
            done  <= 1'b0;
            depth <= '0;
            i     <= '0;
            st    <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (i == count) begin
            done <= 1'b1;
            st   <= S_IDLE;
          end else begin
            p  <= pt_in;
            st <= S_TEST;
          end
        end
        S_TEST: begin
          if (depth >= CW'(2)) begin
            dx1 <= 33'(top_a.lon) - 33'(top_o.lon);
            dy1 <= 33'(top_a.lat) - 33'(top_o.lat);
            dy2 <= 33'(p.lat) - 33'(top_o.lat);
            dx2 <= 33'(p.lon) - 33'(top_o.lon);
            st  <= S_MUL;
          end else begin
            st <= S_PUSH;
          end
        end
        S_MUL: begin
          p1 <= 66'(dx1) * 66'(dy2);
          p2 <= 66'(dy1) * 66'(dx2);
          st <= S_CMP;
        end
        S_CMP: begin
          if (pop) begin
            depth <= depth - CW'(1);
            top_a <= top_o;
            st    <= (depth >= CW'(3)) ? S_REFILL : S_TEST;
          end else begin
            st <= S_PUSH;
          end
        end
        S_REFILL: begin
          top_o <= stk[refill_idx];
          st    <= S_TEST;
        end
        S_PUSH: begin
          stk[depth[IW-1:0]] <= p;
          top_o <= top_a;
          top_a <= p;
          depth <= depth + CW'(1);
          i     <= i + CW'(1);
          st    <= S_FETCH;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/convex_hull_monotone_chain.sv]
// a set of n points loads at one word per cycle while s_tready is high; after
// the last word the sorting chain drains, then both hull scans run side by
// side, then one vertex per cycle is emitted while m_tready is high. one set
// is processed at a time; a new set is taken once the final vertex is
// accepted and the sorting chain has been cleared.
// reset (rst, synchronous) empties the sorting chain and the control state.
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain: convex hull of a point set, clockwise output
// insertion sorting chain of cells feeding two stack-based hull scans
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain #(
  parameter int unsigned MAX_POINTS = chm_pkg::MaxPointsDefault,
  parameter int unsigned FRAC_BITS  = chm_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_lat[30:0], point_lon[62:31], zero
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // vertex_lat[30:0], vertex_lon[62:31], zero
  output logic        m_tlast,   // last_vertex
  output logic        m_tuser    // overflow
);
  import chm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS+1);
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned FracCheck = FRAC_BITS;

  typedef enum logic [2:0] {S_LOAD, S_DRAIN, S_SCAN, S_WAIT, S_EMIT} st_t;

  st_t st;
  logic [CW-1:0] cnt, drain, k, total;
  logic dropped;
  logic [MAX_POINTS:0] cv;
  pt_t cp [MAX_POINTS+1];
  pt_t chold [MAX_POINTS];
  logic clear, scan_start;
  logic [IW-1:0] ui, li, urd, lrd;
  pt_t upt, lpt, urp, lrp;
  logic udone, ldone;
  logic [CW-1:0] nu, nl;
  logic lower_phase;

  // ready only in the load state, held off while the chain clears
  assign s_tready = (st == S_LOAD) && !clear && (FracCheck > 0);
  assign cv[0] = s_tvalid && s_tready && (cnt < CW'(MAX_POINTS));
  assign cp[0] = '{lon: s_tdata[62:31], lat: s_tdata[30:0]};

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    chm_sort_cell u_cell (
      .clk, .rst, .clear,
      .in_valid(cv[g]), .in_pt(cp[g]),
      .out_valid(cv[g+1]), .out_pt(cp[g+1]),
      .held(chold[g])
    );
  end

  assign upt = chold[ui];
  assign lpt = chold[li];

  chm_scan #(.MAX_POINTS(MAX_POINTS)) u_up (
    .clk, .rst, .start(scan_start), .upper(1'b1), .count(cnt),
    .pt_idx(ui), .pt_in(upt), .done(udone), .depth(nu), .rd_idx(urd), .rd_pt(urp)
  );
  chm_scan #(.MAX_POINTS(MAX_POINTS)) u_lo (
    .clk, .rst, .start(scan_start), .upper(1'b0), .count(cnt),
    .pt_idx(li), .pt_in(lpt), .done(ldone), .depth(nl), .rd_idx(lrd), .rd_pt(lrp)
  );

  assign urd = k[IW-1:0];
  assign lower_phase = (k >= nu);
  // lower interior walked east to west: index nl-2 down to 1
  assign lrd = IW'(nl - CW'(2) - (k - nu));

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_LOAD;
      cnt        <= '0;
      dropped    <= 1'b0;
      clear      <= 1'b0;
      scan_start <= 1'b0;
      m_tvalid   <= 1'b0;
      k          <= '0;
      drain      <= '0;
      total      <= '0;
    end else begin
      clear      <= 1'b0;
      scan_start <= 1'b0;
      case (st)
        S_LOAD: begin
          if (s_tvalid && s_tready) begin
            if (cnt < CW'(MAX_POINTS)) begin
              cnt <= cnt + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              drain <= '0;
              st    <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          drain <= drain + CW'(1);
          if (drain == CW'(MAX_POINTS)) begin
            scan_start <= 1'b1;
            st         <= S_SCAN;
          end
        end
        S_SCAN: st <= S_WAIT;
        S_WAIT: begin
          if (udone && ldone) begin
            total <= nu + ((nl >= CW'(2)) ? nl - CW'(2) : '0);
            k     <= '0;
            st    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            if (k == total) begin
              m_tvalid <= 1'b0;
              cnt      <= '0;
              dropped  <= 1'b0;
              clear    <= 1'b1;
              st       <= S_LOAD;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= {1'b0, (lower_phase ? lrp.lon : urp.lon),
                           (lower_phase ? lrp.lat : urp.lat)};
              m_tlast  <= (k + CW'(1) == total);
              m_tuser  <= dropped;
              k        <= k + CW'(1);
            end
          end
        end
        default: st <= S_LOAD;
      endcase
    end
  end

endmodule

[rtl/core/chm_checker.sv]
// ----------------------------------------------------------------------------
// chm_checker: port level checks for the hull block
// ----------------------------------------------------------------------------
module chm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("load while emitting");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[63])
    else $error("pad bit set");
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("word after last vertex");
endmodule

bind convex_hull_monotone_chain chm_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
